FILE: hw/rtl/kpxs_pkg.sv
// Shared types and constants for the known-plaintext key search block.
package kpxs_pkg;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] CFG_SCHEME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd2;

	// Scheme codes
	localparam logic [2:0] SCH_STEP_ADD    = 3'd1; // ((key + i*c2) ^ p) + i*c3
	localparam logic [2:0] SCH_STEP_CONST  = 3'd2; // ((key + i*c2) ^ p) + c
	localparam logic [2:0] SCH_PLAIN_STEP  = 3'd3; // key ^ (p + i*c2)
	localparam logic [2:0] SCH_PLAIN_CONST = 3'd4; // key ^ (p + c)

	// Reset values of the registers
	localparam logic [2:0]            SCHEME_RST  = SCH_STEP_ADD;
	localparam logic [3:0]            LENGTH_RST  = 4'd8;
	localparam logic [CFG_DATA_W-1:0] PATTERN_RST = '0;

	// Bytes held by the pattern register
	localparam int PATTERN_BYTES = 8;

	// Final value of the candidate sweep
	localparam logic [7:0] V_LAST = 8'hff;

	typedef struct packed {
		logic [7:0] enc_byte;
		logic       restart;
	} kpxs_in_t;

	typedef struct packed {
		logic [31:0] match_offset;
		logic [7:0]  found_key;
		logic [7:0]  found_step;
		logic [7:0]  found_addend;
		logic        last_of_run;
		logic        dropped;
	} kpxs_out_t;

	typedef struct packed {
		logic [7:0] key;
		logic [7:0] step;
		logic [7:0] addend;
	} kpxs_cand_t;

endpackage

FILE: hw/rtl/known_plaintext_xor_add_key_search.sv
// Top level of the known-plaintext key search: registers, sweep sequencer, result register.
//
// Each accepted byte enters the window; once enough bytes have arrived the window start is
// tested under the configured scheme by one candidate unit that checks every pattern position
// at once. The sequencer sweeps the candidate values (all 256, or the single one of scheme 3)
// twice: the first sweep counts the matches, the second, run only when there are matches,
// hands them out in sweep order up to the last match reported, so the flags on the first
// result are already final. The second sweep waits while the result register is held by the
// downstream side. The input is ready only between bytes; a finished result may wait in the
// result register while the next byte is taken.
module known_plaintext_xor_add_key_search #(
	parameter int MAX_PATTERN = 8,
	parameter int OFFSET_BITS = 32,
	parameter int MAX_REPORTS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  kpxs_pkg::kpxs_in_t                      in_data,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output kpxs_pkg::kpxs_out_t                     out_data,
	input  logic                                    cfg_we,
	input  logic [kpxs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [kpxs_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import kpxs_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int CNT_W = $clog2(MAX_REPORTS + 2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_COUNT,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [2:0]              scheme_q;
	logic [CFG_DATA_W-1:0]   pattern_q;
	logic [3:0]              length_q;
	logic [7:0]              v_q;
	logic [CNT_W-1:0]        total_q;
	logic [CNT_W-1:0]        rep_q;
	logic [OFFSET_BITS-1:0]  offset_q;
	logic                    out_valid_q;
	kpxs_out_t               out_q;

	logic [LEN_W-1:0]             len;
	logic                         testable;
	logic [OFFSET_BITS-1:0]       offset;
	logic [MAX_PATTERN-1:0][7:0]  win_al;
	logic [MAX_PATTERN-1:0][7:0]  pat;
	logic [MAX_PATTERN-1:0]       en;
	kpxs_cand_t                   cand;
	logic                         hit;
	logic                         kind_ok;
	logic [7:0]                   v_last;
	logic [CNT_W-1:0]             total_nx;
	logic [CNT_W-1:0]             n_rep;
	logic                         over;
	logic                         rep_last;
	logic                         out_free;
	logic                         emit_go;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q  <= SCHEME_RST;
			pattern_q <= PATTERN_RST;
			length_q  <= LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCHEME:  scheme_q  <= cfg_data[2:0];
				CFG_PATTERN: pattern_q <= cfg_data;
				CFG_LENGTH:  length_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Clamp the pattern length into 2..MAX_PATTERN
	assign len = (length_q < 4'd2) ? LEN_W'(2) :
		(int'(length_q) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(length_q);

	always_comb begin
		case (scheme_q) inside
			SCH_STEP_ADD, SCH_STEP_CONST, SCH_PLAIN_STEP, SCH_PLAIN_CONST: kind_ok = 1'b1;
			default: kind_ok = 1'b0;
		endcase
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
		if (i < PATTERN_BYTES) begin : g_reg
			assign pat[i] = pattern_q[8*i +: 8];
		end else begin : g_zero
			assign pat[i] = '0;
		end
		// Scheme 4 checks from position 1, the others from position 2
		assign en[i] = (i < int'(len)) &&
			(i >= ((scheme_q == SCH_PLAIN_CONST) ? 1 : 2));
	end

	assign in_ready = (state_q == ST_IDLE);

	kpxs_window #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (in_valid && in_ready),
		.enc_byte (in_data.enc_byte),
		.restart  (in_data.restart),
		.len      (len),
		.testable (testable),
		.offset   (offset),
		.win_al   (win_al)
	);

	kpxs_cand #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cand (
		.kind (scheme_q),
		.v    (v_q),
		.win  (win_al),
		.pat  (pat),
		.en   (en),
		.cand (cand),
		.hit  (hit)
	);

	// Scheme 3 has a single candidate
	assign v_last   = (scheme_q == SCH_PLAIN_STEP) ? '0 : V_LAST;
	assign total_nx = (hit && total_q != CNT_W'(MAX_REPORTS + 1)) ?
		total_q + CNT_W'(1) : total_q;
	assign over     = (total_q > CNT_W'(MAX_REPORTS));
	assign n_rep    = over ? CNT_W'(MAX_REPORTS) : total_q;
	assign rep_last = ((rep_q + CNT_W'(1)) == n_rep);
	assign out_free = !out_valid_q || out_ready;
	assign emit_go  = (state_q == ST_EMIT) && hit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_q         <= '0;
			total_q     <= '0;
			rep_q       <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					v_q      <= '0;
					total_q  <= '0;
					offset_q <= offset;
					state_q  <= (testable && kind_ok) ? ST_COUNT : ST_IDLE;
				end
				ST_COUNT: begin
					total_q <= total_nx;
					if (v_q == v_last) begin
						v_q     <= '0;
						rep_q   <= '0;
						state_q <= (total_nx == '0) ? ST_IDLE : ST_EMIT;
					end else begin
						v_q <= v_q + 8'd1;
					end
				end
				ST_EMIT: begin
					if (!hit) begin
						v_q <= v_q + 8'd1;
					end else if (out_free) begin
						// Hand out this match, stop after the last one reported
						out_q.match_offset <= 32'(offset_q);
						out_q.found_key    <= cand.key;
						out_q.found_step   <= cand.step;
						out_q.found_addend <= cand.addend;
						out_q.last_of_run  <= rep_last;
						out_q.dropped      <= over;
						rep_q              <= rep_q + CNT_W'(1);
						v_q                <= v_q + 8'd1;
						if (rep_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/kpxs_window.sv
// Byte window, stream offset counter and fill level, with the aligned window start.
module kpxs_window #(
	parameter int MAX_PATTERN = 8,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift,
	input  logic [7:0]                           enc_byte,
	input  logic                                 restart,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]     len,
	output logic                                 testable,
	output logic [OFFSET_BITS-1:0]               offset,
	output logic [MAX_PATTERN-1:0][7:0]          win_al
);
	import kpxs_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = $clog2(MAX_PATTERN);

	logic [7:0]             win_q [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] count_q;
	logic [LEN_W-1:0]       fill_q;

	// Bytes ahead of the fill level are never read, so the window needs no clearing
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[MAX_PATTERN-1] <= enc_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q  <= '0;
		end else if (shift) begin
			if (restart) begin
				count_q <= OFFSET_BITS'(1);
				fill_q  <= LEN_W'(1);
			end else begin
				count_q <= count_q + OFFSET_BITS'(1);
				if (fill_q != LEN_W'(MAX_PATTERN)) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end
		end
	end

	assign testable = (fill_q >= len);
	assign offset   = count_q - OFFSET_BITS'(len);

	// Newest len bytes, oldest of them in lane 0
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < int'(len)) begin
				win_al[i] = win_q[IDX_W'(MAX_PATTERN - int'(len) + i)];
			end else begin
				win_al[i] = '0;
			end
		end
	end

endmodule

FILE: hw/rtl/kpxs_cand.sv
// Candidate unit: derives key, step and addend from one sweep value and checks all lanes.
module kpxs_cand #(
	parameter int MAX_PATTERN = 8
) (
	input  logic [2:0]                  kind,
	input  logic [7:0]                  v,
	input  logic [MAX_PATTERN-1:0][7:0] win,
	input  logic [MAX_PATTERN-1:0][7:0] pat,
	input  logic [MAX_PATTERN-1:0]      en,
	output kpxs_pkg::kpxs_cand_t        cand,
	output logic                        hit
);
	import kpxs_pkg::*;

	logic [7:0]             w0, w1, p0, p1;
	logic [MAX_PATTERN-1:0] lane_ok;

	assign w0 = win[0];
	assign w1 = win[1];
	assign p0 = pat[0];
	assign p1 = pat[1];

	always_comb begin
		cand = '0;
		case (kind)
			SCH_STEP_ADD: begin
				cand.key    = w0 ^ p0;
				cand.addend = v;
				cand.step   = ((w1 - cand.addend) ^ p1) - cand.key;
			end
			SCH_STEP_CONST: begin
				cand.key    = v;
				cand.addend = w0 - (v ^ p0);
				cand.step   = ((w1 - cand.addend) ^ p1) - cand.key;
			end
			SCH_PLAIN_STEP: begin
				cand.key  = w0 ^ p0;
				cand.step = (cand.key ^ w1) - p1;
			end
			SCH_PLAIN_CONST: begin
				cand.key    = v;
				cand.addend = (v ^ w0) - p0;
			end
			default: begin
				cand = '0;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
		localparam logic [7:0] LANE = 8'(i);
		logic [7:0] istep, iadd, lhs, rhs;

		assign istep = cand.step * LANE;
		assign iadd  = cand.addend * LANE;

		always_comb begin
			case (kind)
				SCH_STEP_ADD: begin
					lhs = (cand.key + istep) ^ pat[i];
					rhs = win[i] - iadd;
				end
				SCH_STEP_CONST: begin
					lhs = cand.key + istep;
					rhs = (win[i] - cand.addend) ^ pat[i];
				end
				SCH_PLAIN_STEP: begin
					lhs = istep;
					rhs = (cand.key ^ win[i]) - pat[i];
				end
				SCH_PLAIN_CONST: begin
					lhs = cand.key ^ win[i];
					rhs = pat[i] + cand.addend;
				end
				default: begin
					lhs = '0;
					rhs = '0;
				end
			endcase
		end

		assign lane_ok[i] = !en[i] || (lhs == rhs);
	end

	assign hit = &lane_ok;

endmodule
